### design/stream_byte_reassembler_defines.svh
// Assertion macros shared by the stream byte reassembler RTL.
`ifndef STREAM_BYTE_REASSEMBLER_DEFINES_SVH
`define STREAM_BYTE_REASSEMBLER_DEFINES_SVH

`ifndef SYNTH

// Checked on every rising edge of clk_i while rst_ni is high.
`define SBR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stream_byte_reassembler assertion failed");

// Checked on every rising edge of clk_i, reset included.
`define SBR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("stream_byte_reassembler assertion failed");

`else

`define SBR_ASSERT(lbl, prop)
`define SBR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### design/sbr_pkg.sv
// Shared constants and controller/datapath signal groups of the stream byte reassembler.
`default_nettype none

package sbr_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned IDX_W        = 64;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PEND_W       = 7;

  // Commands from the controller; at most one step command is high per cycle.
  typedef struct packed {
    logic capture;
    logic check;
    logic apply;
    logic scan;
    logic close;
    logic read;
  } dp_cmd_t;

  typedef struct packed {
    logic accepted;
    logic scan_hit;
    logic remain_zero;
  } dp_status_t;

endpackage

`default_nettype wire

### design/sbr_stream_if.sv
// Request channel interfaces for the input items and the result items.
`default_nettype none

interface sbr_in_if;
  logic                        valid;
  logic                        ready;
  logic [sbr_pkg::IDX_W-1:0]   stream_index;
  logic [sbr_pkg::BYTE_W-1:0]  data_byte;
  logic                        has_byte;
  logic                        ends_stream;
  logic [sbr_pkg::IDX_W-1:0]   popped_count;

  modport source (
    output valid, stream_index, data_byte, has_byte, ends_stream, popped_count,
    input  ready
  );
  modport sink (
    input  valid, stream_index, data_byte, has_byte, ends_stream, popped_count,
    output ready
  );
endinterface

interface sbr_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbr_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_valid;
  logic                        run_last;
  logic                        stream_closed;
  logic [sbr_pkg::PEND_W-1:0]  pending_bytes;

  modport source (
    output valid, out_byte, byte_valid, run_last, stream_closed, pending_bytes,
    input  ready
  );
  modport sink (
    input  valid, out_byte, byte_valid, run_last, stream_closed, pending_bytes,
    output ready
  );
endinterface

`default_nettype wire

### design/sbr_ctrl.sv
// Controller state machine that sequences capture, window check, drain scan and result output.
`default_nettype none

module sbr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output sbr_pkg::dp_cmd_t    cmd_o,
  input  sbr_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_SCAN,
    S_CLOSE,
    S_READ,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          state_d    = S_CHECK;
          in_ready_d = 1'b0;
        end
      end
      S_CHECK: state_d = S_APPLY;
      S_APPLY: state_d = status_i.accepted ? S_SCAN : S_CLOSE;
      S_SCAN: begin
        if (!status_i.scan_hit) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (status_i.remain_zero) begin
          state_d     = S_OUT;
          out_valid_d = 1'b1;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d     = S_OUT;
        out_valid_d = 1'b1;
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (status_i.remain_zero) begin
            state_d    = S_IDLE;
            in_ready_d = 1'b1;
          end else begin
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d     = S_IDLE;
        in_ready_d  = 1'b1;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i && in_ready_q;
    cmd_o.check   = (state_q == S_CHECK);
    cmd_o.apply   = (state_q == S_APPLY);
    cmd_o.scan    = (state_q == S_SCAN);
    cmd_o.close   = (state_q == S_CLOSE);
    cmd_o.read    = (state_q == S_READ);
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/sbr_dp.sv
// Datapath: stream position registers, ring memory with valid bits, and result registers.
`default_nettype none

module sbr_dp #(
  parameter int unsigned CAPACITY = sbr_pkg::CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbr_pkg::dp_cmd_t           cmd_i,
  output sbr_pkg::dp_status_t        status_o,
  input  logic [sbr_pkg::IDX_W-1:0]  stream_index_i,
  input  logic [sbr_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       has_byte_i,
  input  logic                       ends_stream_i,
  input  logic [sbr_pkg::IDX_W-1:0]  popped_count_i,
  output logic [sbr_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       byte_valid_o,
  output logic                       run_last_o,
  output logic                       stream_closed_o,
  output logic [sbr_pkg::PEND_W-1:0] pending_bytes_o
);

  localparam int unsigned IW    = sbr_pkg::IDX_W;
  localparam int unsigned LW    = sbr_pkg::IDX_W + 1;
  localparam int unsigned BW    = sbr_pkg::BYTE_W;
  localparam int unsigned PW    = sbr_pkg::PEND_W;
  localparam int unsigned SW    = $clog2(CAPACITY);
  localparam int unsigned SUM_W = SW + 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);

  // Captured item.
  logic [IW-1:0] pos_q;
  logic [IW-1:0] limit_q;
  logic [BW-1:0] data_q;
  logic          has_q;
  logic          ends_q;

  // Stream state.
  logic [IW-1:0]       ne_q;
  logic [SW-1:0]       ne_slot_q;
  logic                end_known_q;
  logic [IW-1:0]       end_pos_q;
  logic                closed_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CW-1:0]       stored_q;

  // Check results and run bookkeeping.
  logic          old_q;
  logic          acc_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] remain_q;
  logic [SW-1:0] rd_slot_q;
  logic [BW-1:0] rd_data_q;
  logic          bv_q;

  logic [BW-1:0] ring_q [CAPACITY];

  logic [LW-1:0]    limit_sum;
  logic [IW-1:0]    limit_d;
  logic [IW-1:0]    diff;
  logic             is_old;
  logic             in_win;
  logic [SUM_W-1:0] slot_sum;
  logic [SW-1:0]    slot_d;
  logic [SW-1:0]    ne_slot_inc;
  logic [SW-1:0]    rd_slot_inc;
  logic             scan_hit;
  logic             do_write;

  // Window end saturates at the top of the index space.
  assign limit_sum = {1'b0, popped_count_i} + LW'(CAPACITY);
  assign limit_d   = limit_sum[LW-1] ? '1 : limit_sum[IW-1:0];

  assign diff     = pos_q - ne_q;
  assign is_old   = (pos_q < ne_q);
  assign in_win   = (pos_q < limit_q) && (diff < IW'(CAPACITY));
  // The ring slot of an accepted byte is the expected slot plus its distance.
  assign slot_sum = {1'b0, ne_slot_q} + {1'b0, diff[SW-1:0]};
  assign slot_d   = (slot_sum >= SUM_W'(CAPACITY)) ? SW'(slot_sum - SUM_W'(CAPACITY))
                                                   : slot_sum[SW-1:0];

  assign ne_slot_inc = (ne_slot_q == SW'(CAPACITY - 1)) ? '0 : ne_slot_q + SW'(1);
  assign rd_slot_inc = (rd_slot_q == SW'(CAPACITY - 1)) ? '0 : rd_slot_q + SW'(1);
  assign scan_hit    = valid_q[ne_slot_q];
  assign do_write    = cmd_i.apply && acc_q && has_q && !valid_q[slot_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q   <= stream_index_i;
      limit_q <= limit_d;
      data_q  <= data_byte_i;
      has_q   <= has_byte_i;
      ends_q  <= ends_stream_i;
    end
    if (cmd_i.check) begin
      slot_q <= slot_d;
    end
    if (cmd_i.apply) begin
      rd_slot_q <= ne_slot_q;
    end else if (cmd_i.read) begin
      rd_slot_q <= rd_slot_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      ring_q[slot_q] <= data_q;
    end
    if (cmd_i.read) begin
      rd_data_q <= ring_q[rd_slot_q];
    end else if (cmd_i.close && (remain_q == '0)) begin
      rd_data_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q        <= '0;
      ne_slot_q   <= '0;
      end_known_q <= 1'b0;
      end_pos_q   <= '0;
      closed_q    <= 1'b0;
      valid_q     <= '0;
      stored_q    <= '0;
      old_q       <= 1'b0;
      acc_q       <= 1'b0;
      remain_q    <= '0;
      bv_q        <= 1'b0;
    end else begin
      if (cmd_i.check) begin
        old_q <= is_old && !closed_q;
        acc_q <= !is_old && in_win && !closed_q;
      end
      if (cmd_i.apply) begin
        remain_q <= '0;
        if ((old_q || acc_q) && ends_q) begin
          end_known_q <= 1'b1;
          end_pos_q   <= has_q ? pos_q + IW'(1) : pos_q;
        end
        if (do_write) begin
          valid_q[slot_q] <= 1'b1;
          stored_q        <= stored_q + CW'(1);
        end
      end
      if (cmd_i.scan && scan_hit) begin
        valid_q[ne_slot_q] <= 1'b0;
        stored_q           <= stored_q - CW'(1);
        ne_q               <= ne_q + IW'(1);
        ne_slot_q          <= ne_slot_inc;
        remain_q           <= remain_q + CW'(1);
      end
      if (cmd_i.close) begin
        if (end_known_q && (ne_q == end_pos_q)) begin
          closed_q <= 1'b1;
        end
        if (remain_q == '0) begin
          bv_q <= 1'b0;
        end
      end
      if (cmd_i.read) begin
        remain_q <= remain_q - CW'(1);
        bv_q     <= 1'b1;
      end
    end
  end

  always_comb begin
    status_o.accepted    = acc_q;
    status_o.scan_hit    = scan_hit;
    status_o.remain_zero = (remain_q == '0);
  end

  assign out_byte_o      = rd_data_q;
  assign byte_valid_o    = bv_q;
  assign run_last_o      = (remain_q == '0);
  assign stream_closed_o = closed_q;
  assign pending_bytes_o = PW'(stored_q);

endmodule

`default_nettype wire

### design/stream_byte_reassembler.sv
// Top level of the stream byte reassembler: controller, datapath and assertions.
// One request at a time: accept, check, apply, a drain scan over the released bytes, close.
// Each byte result takes a ring read, then output; a status-only result skips the read.
// Reset is asynchronous and active low; it empties the ring and clears the stream state.
`default_nettype none
`include "stream_byte_reassembler_defines.svh"

module stream_byte_reassembler #(
  parameter int unsigned CAPACITY = sbr_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbr_in_if.sink    in_req_i,
  sbr_out_if.source out_req_o
);

  localparam int unsigned PEND_W = sbr_pkg::PEND_W;

  // The controller only ever looks at the handshakes and at three status bits;
  // every value of the stream lives in the datapath.
  sbr_pkg::dp_cmd_t    cmd;
  sbr_pkg::dp_status_t status;

  sbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req_i.valid),
    .in_ready_o  (in_req_i.ready),
    .out_ready_i (out_req_o.ready),
    .out_valid_o (out_req_o.valid),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath holds the next expected position, the end mark, the ring of
  // bytes and its valid bits. A drain scan walks the ring one slot a cycle from
  // the next expected position, so the final pending count and closed state
  // are known before the first result of a request is shown.
  sbr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .stream_index_i  (in_req_i.stream_index),
    .data_byte_i     (in_req_i.data_byte),
    .has_byte_i      (in_req_i.has_byte),
    .ends_stream_i   (in_req_i.ends_stream),
    .popped_count_i  (in_req_i.popped_count),
    .out_byte_o      (out_req_o.out_byte),
    .byte_valid_o    (out_req_o.byte_valid),
    .run_last_o      (out_req_o.run_last),
    .stream_closed_o (out_req_o.stream_closed),
    .pending_bytes_o (out_req_o.pending_bytes)
  );

  // The block never takes a request while it still presents a result.
  `SBR_ASSERT(a_no_overlap, !(in_req_i.ready && out_req_o.valid))
  // A status-only result is always the single, last result of its request.
  `SBR_ASSERT(a_status_is_last, (out_req_o.valid && !out_req_o.byte_valid) |-> out_req_o.run_last)
  // The ring never holds more bytes than it has slots.
  `SBR_ASSERT(a_pending_bound, out_req_o.valid |-> (out_req_o.pending_bytes <= PEND_W'(CAPACITY)))
  // Once a request is taken the input side closes until its results are out.
  `SBR_ASSERT(a_busy_after_take, (in_req_i.valid && in_req_i.ready) |=> !in_req_i.ready)
  // Once reset has been seen at an edge, no result is offered at the next one.
  `SBR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_req_o.valid)

endmodule

`default_nettype wire

### tb/stream_byte_reassembler_tb.sv
// Self-checking testbench for the stream byte reassembler.
module stream_byte_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W  = sbr_pkg::IDX_W;
  localparam int unsigned BYTE_W = sbr_pkg::BYTE_W;
  localparam int unsigned PEND_W = sbr_pkg::PEND_W;

  // Ring size of the block under test, and the limits of the run.
  localparam int unsigned CAP        = sbr_pkg::CAPACITY_DEF;
  localparam int unsigned RAND_ITEMS = 90;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned TAIL       = 40;

  // One input request: a byte (or a bare end marker) at an absolute position.
  typedef struct packed {
    logic [IDX_W-1:0]  stream_index;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              ends_stream;
    logic [IDX_W-1:0]  popped_count;
  } seg_byte_t;

  // One result request: an in-order byte or a status-only word.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              stream_closed;
    logic [PEND_W-1:0] pending_bytes;
  } asm_result_t;

  // Our own view of the reassembly state.
  typedef struct {
    logic [IDX_W-1:0]  next_pos;
    logic              end_seen;
    logic [IDX_W-1:0]  end_pos;
    logic              closed;
    logic [BYTE_W-1:0] ring [CAP];
    logic              held [CAP];
    int unsigned       held_cnt;
  } reasm_state_t;

  // Keeps the predicted reassembly state and the results still owed by the block.
  class stream_ledger;
    reasm_state_t st;
    asm_result_t  owed_results[$];
    int unsigned  errors;

    function new();
      st.next_pos = '0;
      st.end_seen = 1'b0;
      st.end_pos  = '0;
      st.closed   = 1'b0;
      st.held_cnt = 0;
      foreach (st.held[i]) st.held[i] = 1'b0;
      errors = 0;
    endfunction

    // Applies one request to a state and returns the results it causes.
    static function automatic void reassemble(inout reasm_state_t s, input seg_byte_t it,
                                              output asm_result_t res[$]);
      logic [IDX_W:0]   lim;
      logic [IDX_W-1:0] win_end;
      int unsigned      slot;
      asm_result_t      r;
      res = {};
      if (!s.closed) begin
        if (it.stream_index < s.next_pos) begin
          // Stale byte or marker: the data is dropped, but an end mark still counts.
          if (it.ends_stream) begin
            s.end_seen = 1'b1;
            s.end_pos  = it.stream_index + 64'(it.has_byte);
          end
        end else begin
          // The window end saturates instead of wrapping.
          lim     = {1'b0, it.popped_count} + 65'(CAP);
          win_end = lim[IDX_W] ? '1 : lim[IDX_W-1:0];
          if (it.stream_index < win_end && (it.stream_index - s.next_pos) < 64'(CAP)) begin
            if (it.ends_stream) begin
              s.end_seen = 1'b1;
              s.end_pos  = it.stream_index + 64'(it.has_byte);
            end
            if (it.has_byte) begin
              slot = int'(it.stream_index % CAP);
              if (!s.held[slot]) begin
                s.held[slot] = 1'b1;
                s.ring[slot] = it.data_byte;
                s.held_cnt++;
              end
            end
            while (res.size() < CAP && s.held[int'(s.next_pos % CAP)]) begin
              slot         = int'(s.next_pos % CAP);
              r            = '0;
              r.out_byte   = s.ring[slot];
              r.byte_valid = 1'b1;
              s.held[slot] = 1'b0;
              s.held_cnt--;
              s.next_pos++;
              res.push_back(r);
            end
          end
        end
        if (s.end_seen && s.next_pos == s.end_pos) s.closed = 1'b1;
      end
      if (res.size() == 0) res.push_back('0);
      foreach (res[i]) begin
        res[i].run_last      = (i == res.size() - 1);
        res[i].stream_closed = s.closed;
        res[i].pending_bytes = s.held_cnt[PEND_W-1:0];
      end
    endfunction

    function void note_request(seg_byte_t it);
      asm_result_t res[$];
      reassemble(st, it, res);
      foreach (res[i]) owed_results.push_back(res[i]);
    endfunction

    // Tells whether a request would close the stream, without changing the state.
    function bit would_close(seg_byte_t it);
      reasm_state_t tmp;
      asm_result_t  res[$];
      tmp = st;
      reassemble(tmp, it, res);
      return tmp.closed;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(asm_result_t got);
      asm_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with none outstanding: out_byte %0h byte_valid %0b",
               got.out_byte, got.byte_valid);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("byte_valid", want.byte_valid, got.byte_valid);
      check_field("run_last", want.run_last, got.run_last);
      check_field("stream_closed", want.stream_closed, got.stream_closed);
      check_field("pending_bytes", want.pending_bytes, got.pending_bytes);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sbr_in_if  in_if ();
  sbr_out_if out_if ();

  stream_byte_reassembler #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_if),
    .out_req_o(out_if)
  );

  stream_ledger board = new();

  // When idle_on is low, neither side inserts gaps. When close_ok is low, any
  // request that would close the stream is defused first, since the stream can
  // close only once per run and everything after that is ignored.
  bit idle_on  = 1'b0;
  bit close_ok = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls in random bursts while idle_on is set.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Every result request accepted by the handshake is checked against the oldest
  // outstanding prediction. Values are read at the edge, before any update.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result({out_if.out_byte, out_if.byte_valid, out_if.run_last,
                          out_if.stream_closed, out_if.pending_bytes});
    end
  end

  // Watchdog: too long without any request moving on either channel means a hang.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic seg_byte_t mk(logic [IDX_W-1:0] pos, logic [BYTE_W-1:0] dat,
                                   logic has, logic ends, logic [IDX_W-1:0] popped);
    seg_byte_t it;
    it.stream_index = pos;
    it.data_byte    = dat;
    it.has_byte     = has;
    it.ends_stream  = ends;
    it.popped_count = popped;
    return it;
  endfunction

  // A consumer count a little behind the next expected position, as in normal use.
  // This narrows the window, so bytes near its far end get dropped now and then.
  function automatic logic [IDX_W-1:0] window_base();
    logic [IDX_W-1:0] nx;
    nx = board.st.next_pos;
    return nx - $urandom_range(0, (nx > 12) ? 12 : int'(nx));
  endfunction

  // Presents one input request and holds it until the block takes it. Valid stays
  // high from one request to the next unless a gap is inserted in between.
  task automatic drive_request(input seg_byte_t it);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.stream_index <= it.stream_index;
    in_if.data_byte    <= it.data_byte;
    in_if.has_byte     <= it.has_byte;
    in_if.ends_stream  <= it.ends_stream;
    in_if.popped_count <= it.popped_count;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_request(it);
  endtask

  // Sends a request, but outside the closing phase it first defuses a pending end:
  // a stale marker at position 0 moves the end below the next expected position,
  // where it can never be reached. The request then goes without its end mark.
  task automatic push_request(input seg_byte_t it);
    if (!close_ok && board.would_close(it)) begin
      drive_request(mk('0, 8'h00, 1'b0, 1'b1, board.st.next_pos));
      it.ends_stream = 1'b0;
    end
    drive_request(it);
  endtask

  // Sends the bytes of one segment in shuffled order, sometimes with one byte
  // repeated under new data, which the block must ignore.
  task automatic send_run(input logic [IDX_W-1:0] first, input int unsigned count,
                          input bit mark_end, input bit exact_popped);
    logic [IDX_W-1:0] order[$];
    logic [IDX_W-1:0] tmp;
    int unsigned      j;
    seg_byte_t        it;
    for (int unsigned i = 0; i < count; i++) order.push_back(first + i);
    for (int i = int'(count) - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (count > 1 && $urandom_range(0, 5) == 0) begin
      order.push_back(order[$urandom_range(0, count - 1)]);
    end
    foreach (order[k]) begin
      it = mk(order[k], BYTE_W'($urandom), 1'b1, mark_end && order[k] == first + count - 1,
              exact_popped ? board.st.next_pos : window_base());
      push_request(it);
    end
  endtask

  initial begin
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] gap;
    int unsigned      rand_sent;
    int unsigned      pick;
    int unsigned      len;
    bit               fill_done;

    in_if.valid        <= 1'b0;
    in_if.stream_index <= '0;
    in_if.data_byte    <= '0;
    in_if.has_byte     <= 1'b0;
    in_if.ends_stream  <= 1'b0;
    in_if.popped_count <= '0;
    rand_sent = 0;
    fill_done = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no gaps. In order: a byte that goes straight out; a byte held
    // ahead; a duplicate that must not replace it; a zero byte; the byte that
    // releases a run of three; stale bytes and a stale marker, the latter two
    // carrying end marks; a byte just past the consumer window; one at the last
    // window slot; one past the ring reach under a saturated window; an all-ones
    // position with all-ones consumer count; accepted end marks on a bare marker
    // and on a byte, the second overriding the first; and a bare marker without end.
    push_request(mk(64'd0, 8'hA5, 1'b1, 1'b0, 64'd0));
    push_request(mk(64'd3, 8'hFF, 1'b1, 1'b0, 64'd0));
    push_request(mk(64'd3, 8'h11, 1'b1, 1'b0, 64'd0));
    push_request(mk(64'd2, 8'h00, 1'b1, 1'b0, 64'd0));
    push_request(mk(64'd1, 8'h5A, 1'b1, 1'b0, 64'd1));
    push_request(mk(64'd0, 8'h77, 1'b1, 1'b0, 64'd4));
    push_request(mk(64'd1, 8'h42, 1'b1, 1'b1, 64'd4));
    push_request(mk(64'd0, 8'h00, 1'b0, 1'b1, 64'd4));
    push_request(mk(64'd68, 8'hC3, 1'b1, 1'b0, 64'd4));
    push_request(mk(64'd67, 8'h3C, 1'b1, 1'b0, 64'd4));
    push_request(mk(64'd68, 8'h99, 1'b1, 1'b0, '1));
    push_request(mk('1, 8'hFF, 1'b1, 1'b1, '1));
    push_request(mk(64'd6, 8'h81, 1'b1, 1'b0, '1));
    push_request(mk(64'd60, 8'h00, 1'b0, 1'b1, 64'd4));
    push_request(mk(64'd50, 8'h33, 1'b1, 1'b1, 64'd4));
    push_request(mk(64'd5, 8'h00, 1'b0, 1'b0, 64'd4));
    push_request(mk(64'd4, 8'h18, 1'b1, 1'b0, 64'd4));

    // Random part. Mostly short segments near the next expected position, so
    // that bytes pile up and drain in runs; once, the whole ring is filled and
    // released by a single byte. The rest is noise: stale requests, positions
    // far outside the window, bare markers and inconsistent consumer counts.
    while (rand_sent < RAND_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      nx      = board.st.next_pos;
      if (!fill_done && rand_sent >= 30) begin
        send_run(nx + 1, CAP - 1, 1'b0, 1'b1);
        push_request(mk(board.st.next_pos, BYTE_W'($urandom), 1'b1, 1'b0,
                        board.st.next_pos));
        fill_done = 1'b1;
        rand_sent += CAP;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          len = $urandom_range(1, 8);
          send_run(nx + $urandom_range(0, 12), len, $urandom_range(0, 4) == 0, 1'b0);
          rand_sent += len;
        end else begin
          case (pick)
            6: begin
              push_request(mk(nx - 1 - $urandom_range(0, (nx > 41) ? 40 : int'(nx) - 1),
                              BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), window_base()));
            end
            7: begin
              push_request(mk(($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                                          : nx + 64 + $urandom_range(0, 200),
                              BYTE_W'($urandom), 1'b1, 1'($urandom_range(0, 1)),
                              window_base()));
            end
            8: begin
              push_request(mk(nx + $urandom_range(0, 63), BYTE_W'($urandom), 1'b0,
                              1'($urandom_range(0, 1)), nx));
            end
            default: begin
              push_request(mk(nx + $urandom_range(0, 70), BYTE_W'($urandom), 1'b1, 1'b0,
                              ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                                          : nx + $urandom_range(1, 100)));
            end
          endcase
          rand_sent++;
        end
      end
    end

    // Closing phase, no gaps. A few more bytes are held, the end is placed at the
    // first hole past the held run, and the byte at the next expected position
    // then drains everything up to it, which closes the stream. Requests after
    // that are ignored and each gives a single status result.
    idle_on  = 1'b0;
    close_ok = 1'b1;
    send_run(board.st.next_pos + 1, $urandom_range(1, 6), 1'b0, 1'b1);
    nx  = board.st.next_pos;
    gap = nx + 1;
    while (board.st.held[int'(gap % CAP)]) gap++;
    push_request(mk(gap, BYTE_W'($urandom), 1'b0, 1'b1, nx));
    push_request(mk(nx, BYTE_W'($urandom), 1'b1, 1'b0, nx));
    nx = board.st.next_pos;
    push_request(mk(nx, BYTE_W'($urandom), 1'b1, 1'b1, nx));
    push_request(mk(nx + 1, BYTE_W'($urandom), 1'b1, 1'b0, nx));
    push_request(mk({$urandom, $urandom}, BYTE_W'($urandom), 1'b0, 1'b1,
                    {$urandom, $urandom}));
    in_if.valid <= 1'b0;

    // Drain: wait for every predicted result, then a little longer so that any
    // stray extra result still shows up as a failure.
    while (board.owed_results.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
